// ===== hdl/bdpc_pkg.sv =====
package bdpc_pkg;

    localparam int OPC_W   = 1;
    localparam int BASE_W  = 4;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 6;
    localparam int KW      = 32;
    localparam int SIZE_W  = 7;
    localparam int RADIX_W = 5;
    localparam int CFG_W   = 7;
    localparam int CFG_AW  = 1;

    localparam int DEF_MAX_SIZE   = 64;
    localparam int DEF_MAX_BASES  = 16;
    localparam int DEF_MAX_DIGITS = 32;

    localparam logic [OPC_W-1:0] OP_LOAD     = 1'b0;
    localparam logic [OPC_W-1:0] OP_GENERATE = 1'b1;

    localparam logic [CFG_AW-1:0] CFG_PERM_SIZE  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_BASE_COUNT = 1'b1;

    typedef struct packed {
        logic               start;
        logic [KW-1:0]      dividend;
        logic [RADIX_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [KW-1:0]      quotient;
        logic [RADIX_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== hdl/bdpc_ram.sv =====
module bdpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bdpc_divider.sv =====
module bdpc_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  bdpc_pkg::div_req_t  req,
    output bdpc_pkg::div_rsp_t  rsp
);

    import bdpc_pkg::*;

    localparam int CNT_W = $clog2(KW);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [KW-1:0]      q_reg, q_next;
    logic [RADIX_W-1:0] r_reg, r_next;
    logic [RADIX_W-1:0] div_reg, div_next;
    logic [RADIX_W:0]   shifted;
    logic               ge;

    assign shifted = {r_reg, q_reg[KW-1]};
    assign ge      = shifted >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = req.dividend;
            r_next    = '0;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            // restoring step, one quotient bit per cycle
            r_next   = ge ? RADIX_W'(shifted - {1'b0, div_reg}) : shifted[RADIX_W-1:0];
            q_next   = {q_reg[KW-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(KW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        r_reg   <= r_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;

endmodule

// ===== hdl/base_digit_permutation_composer_core.sv =====
// channel  | direction | handshake        | payload
// s_       | in        | s_valid/s_ready  | s_opcode s_base_index s_position s_entry_value
//          |           |                  | s_perm_index
// m_       | out       | m_valid/m_ready  | m_out_position m_out_value m_last
// cfg_     | in        | cfg_we           | cfg_addr cfg_wdata
//
// a load is one write into the base table memory.
// a generate with D digits runs the bit-serial radix divider once per digit for a nonzero
// index, then size * D lookups of composition, one table read per cycle unless held.
// reset returns control and configuration to their reset values only; the base table holds nothing until loaded.
// a low m_ready with m_valid high holds the sequencer at the result step; s_ready is high only when idle.
module base_digit_permutation_composer_core #(
    parameter int MAX_SIZE   = bdpc_pkg::DEF_MAX_SIZE,
    parameter int MAX_BASES  = bdpc_pkg::DEF_MAX_BASES,
    parameter int MAX_DIGITS = bdpc_pkg::DEF_MAX_DIGITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [bdpc_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [bdpc_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bdpc_pkg::OPC_W-1:0]   s_opcode,
    input  logic [bdpc_pkg::BASE_W-1:0]  s_base_index,
    input  logic [bdpc_pkg::POS_W-1:0]   s_position,
    input  logic [bdpc_pkg::VAL_W-1:0]   s_entry_value,
    input  logic [bdpc_pkg::KW-1:0]      s_perm_index,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bdpc_pkg::POS_W-1:0]   m_out_position,
    output logic [bdpc_pkg::VAL_W-1:0]   m_out_value,
    output logic                         m_last
);

    import bdpc_pkg::*;

    localparam int PW     = $clog2(MAX_SIZE);
    localparam int BW     = $clog2(MAX_BASES);
    localparam int TAW    = BW + PW;
    localparam int TDEPTH = MAX_BASES * (2 ** PW);
    localparam int DAW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW     = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PREP,
        ST_FIRST,
        ST_LOOK,
        ST_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [SIZE_W-1:0]  perm_size_reg;
    logic [RADIX_W-1:0] base_count_reg;
    logic [KW-1:0]      k_reg, k_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [SIZE_W-1:0]  i_reg, i_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [DAW-1:0]     d_reg, d_next;
    logic               m_valid_reg, m_valid_next;
    logic [POS_W-1:0]   m_pos_reg, m_pos_next;
    logic [VAL_W-1:0]   m_val_reg, m_val_next;
    logic               m_last_reg, m_last_next;

    logic [SIZE_W-1:0]  size_eff;
    logic [RADIX_W-1:0] radix_eff;
    logic               s_accept;
    logic               out_load;
    logic               run_last;

    logic               tbl_we, tbl_re;
    logic [TAW-1:0]     tbl_waddr, tbl_raddr;
    logic [VAL_W-1:0]   tbl_rdata;
    logic               dig_we, dig_re;
    logic [DAW-1:0]     dig_waddr, dig_raddr;
    logic [BW-1:0]      dig_wdata, dig_rdata;

    logic [PW-1:0]      step_x;
    logic               step_en;
    logic [DAW-1:0]     n_last;
    logic [DAW-1:0]     step_d;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [PW-1:0]      mod_lut [2 ** VAL_W];

    // stored images reduced to a table position
    for (genvar g = 0; g < 2 ** VAL_W; g++) begin : g_mod
        assign mod_lut[g] = PW'(g % MAX_SIZE);
    end

    bdpc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TDEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (s_entry_value),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    bdpc_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .aclk  (aclk),
        .we    (dig_we),
        .waddr (dig_waddr),
        .wdata (dig_wdata),
        .re    (dig_re),
        .raddr (dig_raddr),
        .rdata (dig_rdata)
    );

    bdpc_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            perm_size_reg  <= SIZE_W'(64);
            base_count_reg <= RADIX_W'(2);
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_PERM_SIZE:  perm_size_reg  <= cfg_wdata[SIZE_W-1:0];
                CFG_BASE_COUNT: base_count_reg <= cfg_wdata[RADIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (perm_size_reg == '0) begin
            size_eff = SIZE_W'(1);
        end else if (int'(perm_size_reg) > MAX_SIZE) begin
            size_eff = SIZE_W'(MAX_SIZE);
        end else begin
            size_eff = perm_size_reg;
        end
        if (base_count_reg < RADIX_W'(2)) begin
            radix_eff = RADIX_W'(2);
        end else if (int'(base_count_reg) > MAX_BASES) begin
            radix_eff = RADIX_W'(MAX_BASES);
        end else begin
            radix_eff = base_count_reg;
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign n_last   = DAW'(n_reg - CW'(1));
    assign step_d   = (d_reg != '0) ? DAW'(d_reg - DAW'(1)) : n_last;
    assign out_load = (state_reg == ST_RESULT) && (!m_valid_reg || m_ready);
    assign run_last = ({1'b0, i_reg} + (SIZE_W + 1)'(1)) == {1'b0, size_reg};

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        radix_next   = radix_reg;
        size_next    = size_reg;
        i_next       = i_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_pos_next   = m_pos_reg;
        m_val_next   = m_val_reg;
        m_last_next  = m_last_reg;

        tbl_we    = 1'b0;
        tbl_waddr = {BW'(s_base_index), PW'(s_position)};
        dig_we    = 1'b0;
        dig_waddr = n_reg[DAW-1:0];
        dig_wdata = BW'(div_rsp.remainder);
        dig_re    = 1'b0;
        dig_raddr = step_d;
        step_en   = 1'b0;
        step_x    = mod_lut[tbl_rdata];

        div_req.start    = 1'b0;
        div_req.dividend = k_reg;
        div_req.divisor  = radix_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_opcode == OP_LOAD) begin
                        tbl_we = (int'(s_base_index) < MAX_BASES)
                              && (int'(s_position) < MAX_SIZE);
                    end else begin
                        size_next  = size_eff;
                        radix_next = radix_eff;
                        i_next     = '0;
                        if (s_perm_index == '0) begin
                            dig_we     = 1'b1;
                            dig_waddr  = '0;
                            dig_wdata  = '0;
                            n_next     = CW'(1);
                            state_next = ST_PREP;
                        end else begin
                            k_next     = s_perm_index;
                            n_next     = '0;
                            state_next = ST_DIV_START;
                        end
                    end
                end
            end
            ST_DIV_START: begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    dig_we = 1'b1;
                    k_next = div_rsp.quotient;
                    n_next = n_reg + CW'(1);
                    if ((div_rsp.quotient != '0) && (int'(n_reg) + 1 < MAX_DIGITS)) begin
                        state_next = ST_DIV_START;
                    end else begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                dig_re     = 1'b1;
                dig_raddr  = n_last;
                d_next     = n_last;
                state_next = ST_FIRST;
            end
            ST_FIRST: begin
                step_en = 1'b1;
                step_x  = PW'(i_reg);
            end
            ST_LOOK: begin
                step_en = 1'b1;
            end
            ST_RESULT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_pos_next   = i_reg[POS_W-1:0];
                    m_val_next   = tbl_rdata;
                    m_last_next  = run_last;
                    if (run_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next  = i_reg + SIZE_W'(1);
                        step_en = 1'b1;
                        step_x  = PW'(i_reg + SIZE_W'(1));
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // one lookup per cycle unless held at the result step, digits read one step ahead
        tbl_re    = step_en;
        tbl_raddr = {dig_rdata, step_x};
        if (step_en) begin
            dig_re     = 1'b1;
            d_next     = step_d;
            state_next = (d_reg != '0) ? ST_LOOK : ST_RESULT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            d_reg       <= '0;
            i_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            d_reg       <= d_next;
            i_reg       <= i_next;
            m_valid_reg <= m_valid_next;
        end
        k_reg      <= k_next;
        radix_reg  <= radix_next;
        size_reg   <= size_next;
        m_pos_reg  <= m_pos_next;
        m_val_reg  <= m_val_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_position = m_pos_reg;
    assign m_out_value    = m_val_reg;
    assign m_last         = m_last_reg;

    a_digit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIRST || state_reg == ST_LOOK || state_reg == ST_RESULT)
        |-> (n_reg != '0) && (int'(n_reg) <= MAX_DIGITS))
        else $error("digit count out of range during composition");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside of digit extraction");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && run_last) |=> (state_reg == ST_IDLE) && m_valid && m_last)
        else $error("final position did not end the run");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> int'(i_reg) < MAX_SIZE)
        else $error("reported position beyond table size");

endmodule

// ===== tb/sv/base_digit_permutation_composer_core_tb.sv =====
module base_digit_permutation_composer_core_tb;
    import bdpc_pkg::*;

    localparam int TABLE_BASES = DEF_MAX_BASES;
    localparam int TABLE_SIZE  = DEF_MAX_SIZE;
    localparam int DIGIT_SLOTS = DEF_MAX_DIGITS;
    localparam int FULL_BASES  = 2;
    localparam int LOW_BLOCK   = 4;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] image;
        logic             last;
    } image_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [OPC_W-1:0]    s_opcode;
    logic [BASE_W-1:0]   s_base_index;
    logic [POS_W-1:0]    s_position;
    logic [VAL_W-1:0]    s_entry_value;
    logic [KW-1:0]       s_perm_index;
    logic                m_valid;
    logic                m_ready;
    logic [POS_W-1:0]    m_out_position;
    logic [VAL_W-1:0]    m_out_value;
    logic                m_last;

    logic [VAL_W-1:0]    perm_table [TABLE_BASES][TABLE_SIZE];
    logic [SIZE_W-1:0]   perm_size_q;
    logic [RADIX_W-1:0]  base_count_q;
    image_t              pending_images [$];
    int                  mismatches;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_left;

    base_digit_permutation_composer_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_base_index   (s_base_index),
        .s_position     (s_position),
        .s_entry_value  (s_entry_value),
        .s_perm_index   (s_perm_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_position (m_out_position),
        .m_out_value    (m_out_value),
        .m_last         (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    // composed permutation for index k under the current table and configuration
    task automatic predict_images(input logic [KW-1:0] k);
        int unsigned size;
        int unsigned radix;
        int unsigned n;
        int unsigned rest;
        int unsigned x;
        int unsigned digits [DIGIT_SLOTS];
        image_t      img;
        size = perm_size_q;
        if (size < 1) size = 1;
        if (size > TABLE_SIZE) size = TABLE_SIZE;
        radix = base_count_q;
        if (radix < 2) radix = 2;
        if (radix > TABLE_BASES) radix = TABLE_BASES;
        rest = k;
        n = 0;
        if (rest == 0) begin
            digits[0] = 0;
            n = 1;
        end
        while (rest > 0 && n < DIGIT_SLOTS) begin
            digits[n] = rest % radix;
            rest = rest / radix;
            n++;
        end
        for (int i = 0; i < int'(size); i++) begin
            x = i;
            for (int d = int'(n) - 1; d >= 0; d--) x = perm_table[digits[d]][x % TABLE_SIZE];
            img.position = POS_W'(i);
            img.image    = VAL_W'(x);
            img.last     = (i + 1 == int'(size));
            pending_images.push_back(img);
        end
    endtask

    task automatic check_image();
        image_t want;
        if (pending_images.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected transaction: pos %0d value %0d last %0b",
                         m_out_position, m_out_value, m_last);
        end else begin
            want = pending_images.pop_front();
            if (m_out_position !== want.position || m_out_value !== want.image ||
                m_last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected pos %0d value %0d last %0b, got pos %0d value %0d last %0b",
                             want.position, want.image, want.last,
                             m_out_position, m_out_value, m_last);
            end
        end
    endtask

    // result side: check, then decide ready for the next cycle
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) check_image();
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input logic [OPC_W-1:0] op, input logic [BASE_W-1:0] b,
                             input logic [POS_W-1:0] p, input logic [VAL_W-1:0] v,
                             input logic [KW-1:0] k);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_base_index  <= b;
        s_position    <= p;
        s_entry_value <= v;
        s_perm_index  <= k;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (op == OP_LOAD) perm_table[b][p] = v;
        else predict_images(k);
    endtask

    task automatic send_generate(input logic [KW-1:0] k);
        send_item(OP_GENERATE, BASE_W'($urandom), POS_W'($urandom), VAL_W'($urandom), k);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_images.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_config(input logic [SIZE_W-1:0] size, input logic [RADIX_W-1:0] radix);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_PERM_SIZE;
        cfg_wdata <= CFG_W'(size);
        @(posedge aclk);
        cfg_addr  <= CFG_BASE_COUNT;
        cfg_wdata <= CFG_W'(radix);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        perm_size_q  = size;
        base_count_q = radix;
    endtask

    function automatic logic [KW-1:0] pick_index();
        case ($urandom_range(3))
            0: return KW'($urandom_range(0, 20));
            1: return KW'($urandom);
            2: return KW'($urandom) >> $urandom_range(31);
            default: return 32'hFFFF_FFFF >> $urandom_range(31);
        endcase
    endfunction

    // bases 0 and 1 written in full, the rest only in the low block
    // every base maps the low block onto itself, so a radix above 2 stays there for small sizes
    task automatic test_table_fill();
        logic [VAL_W-1:0] order [TABLE_SIZE];
        logic [VAL_W-1:0] tmp;
        int               j;
        int               top;
        for (int b = 0; b < TABLE_BASES; b++) begin
            top = (b < FULL_BASES) ? TABLE_SIZE : LOW_BLOCK;
            for (int p = 0; p < TABLE_SIZE; p++) order[p] = VAL_W'(p);
            for (int p = LOW_BLOCK - 1; p > 0; p--) begin
                j = $urandom_range(p);
                tmp = order[p];
                order[p] = order[j];
                order[j] = tmp;
            end
            for (int p = top - 1; p > LOW_BLOCK; p--) begin
                j = $urandom_range(p, LOW_BLOCK);
                tmp = order[p];
                order[p] = order[j];
                order[j] = tmp;
            end
            for (int p = 0; p < top; p++)
                send_item(OP_LOAD, BASE_W'(b), POS_W'(p), order[p], KW'($urandom));
        end
    endtask

    task automatic test_directed_cases();
        send_generate(32'd0);
        send_generate(32'd1);
        send_generate(32'hFFFF_FFFF);
        send_item(OP_LOAD, 4'd15, 6'd63, 6'd0, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 4'd0, 6'd63, 6'd63, 32'd0);
        send_generate(32'd2);
        write_config(7'd1, 5'd16);
        send_generate(32'hFFFF_FFFF);
        send_generate(32'd16);
        send_generate(32'd15);
        write_config(7'd0, 5'd0);
        send_generate(32'd5);
        write_config(7'd127, 5'd1);
        send_generate(32'h8000_0000);
        write_config(7'd3, 5'd31);
        send_generate(32'h1234_5678);
        write_config(7'd2, 5'd1);
        send_generate(32'd3);
        write_config(7'd64, 5'd2);
        send_generate(32'hFFFF_FFFF);
    endtask

    // long receiver hold while generates keep coming
    task automatic test_input_backpressure();
        write_config(7'd4, 5'd4);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left = 1500;
        repeat (6) send_generate(pick_index());
    endtask

    task automatic test_paced_generates();
        write_config(7'd4, 5'd3);
        repeat (5) begin
            send_generate(pick_index());
            s_valid <= 1'b0;
            while (pending_images.size() != 0) @(posedge aclk);
        end
    endtask

    task automatic random_transaction();
        int unsigned       pick;
        int                lo;
        int                hi;
        logic [BASE_W-1:0] b;
        logic [POS_W-1:0]  p1;
        logic [POS_W-1:0]  p2;
        logic [VAL_W-1:0]  v1;
        logic [VAL_W-1:0]  v2;
        pick = $urandom_range(99);
        b  = BASE_W'($urandom);
        lo = 0;
        hi = LOW_BLOCK - 1;
        if (int'(b) < FULL_BASES && $urandom_range(1) == 1) begin
            lo = LOW_BLOCK;
            hi = TABLE_SIZE - 1;
        end
        p1 = POS_W'($urandom_range(hi, lo));
        p2 = POS_W'($urandom_range(hi, lo));
        if (pick < 45) begin
            send_generate(pick_index());
        end else if (pick < 85) begin
            // swap two entries so the base stays a permutation
            v1 = perm_table[b][p1];
            v2 = perm_table[b][p2];
            send_item(OP_LOAD, b, p1, v2, KW'($urandom));
            send_item(OP_LOAD, b, p2, v1, KW'($urandom));
        end else begin
            send_item(OP_LOAD, b, p1, VAL_W'($urandom_range(hi, lo)), KW'($urandom));
        end
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        logic [SIZE_W-1:0]  size;
        logic [RADIX_W-1:0] radix;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (2) begin
            if ($urandom_range(1) == 1) begin
                radix = RADIX_W'($urandom_range(0, 2));
                case ($urandom_range(5))
                    4: size = SIZE_W'($urandom_range(13, 64));
                    5: size = SIZE_W'($urandom_range(0, 127));
                    default: size = SIZE_W'($urandom_range(1, 12));
                endcase
            end else begin
                radix = RADIX_W'($urandom_range(3, 31));
                size  = SIZE_W'($urandom_range(0, LOW_BLOCK));
            end
            write_config(size, radix);
            repeat (7) random_transaction();
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= CFG_PERM_SIZE;
        cfg_wdata     <= '0;
        s_valid       <= 1'b0;
        s_opcode      <= OP_LOAD;
        s_base_index  <= '0;
        s_position    <= '0;
        s_entry_value <= '0;
        s_perm_index  <= '0;
        perm_size_q    = SIZE_W'(DEF_MAX_SIZE);
        base_count_q   = RADIX_W'(2);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_table_fill();
        test_directed_cases();
        test_input_backpressure();
        test_paced_generates();
        test_random_phase(0, 0);
        test_random_phase(64, 0);
        test_random_phase(0, 64);
        test_random_phase(28, 28);

        s_valid <= 1'b0;
        for (int n = 0; n < 200000 && pending_images.size() != 0; n++) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_images.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
